[design/lkbc_pkg.sv]
package lkbc_pkg;

  localparam int KEY_W = 32;
  localparam int DATA_W = 64;
  localparam int LEN_W = 4;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] write_data;
    logic [LEN_W-1:0]  write_length;
  } lkbc_req_t;

endpackage

[design/lkbc_front.sv]
module lkbc_front import lkbc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lkbc_req_t in_req,
  output logic      q_valid,
  input  logic      q_ready,
  output lkbc_req_t q_req
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lkbc_req_t         slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       fill;
  logic              push;
  logic              pop;

  assign in_ready = (fill != (PW+1)'(DEPTH));
  assign q_valid  = (fill != '0);
  assign q_req    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        // store the transaction at the tail
        slots[wr_ptr] <= in_req;
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

[design/lkbc_back.sv]
module lkbc_back import lkbc_pkg::*; #(
  parameter int ENTRIES     = 16,
  parameter int BLOCK_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  lkbc_req_t         q_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [DATA_W-1:0] read_data,
  output logic [LEN_W-1:0]  read_length
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = IW + 1;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_LOOKUP  = 2'd1;
  localparam logic [1:0] S_UPDATE  = 2'd2;
  localparam logic [1:0] S_RESULT  = 2'd3;

  logic [KEY_W-1:0]  entry_key     [ENTRIES];
  logic [DATA_W-1:0] entry_payload [ENTRIES];
  logic [LEN_W-1:0]  entry_bytes   [ENTRIES];
  logic [IW-1:0]     recency_rank  [ENTRIES];
  logic [CW-1:0]     used_count;

  logic [1:0]        state;
  lkbc_req_t         req;
  logic              found;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     old_rank;

  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] lru_vec;
  logic               match_any;
  logic [IW-1:0]      match_idx;
  logic [IW-1:0]      lru_idx;
  logic [LEN_W-1:0]   sat_len;
  logic [DATA_W-1:0]  masked_data;

  // Per-entry compare, then priority encode (lowest index wins).
  always_comb begin
    match_idx = '0;
    lru_idx   = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      match_vec[j] = (CW'(j) < used_count) && (entry_key[j] == req.key);
      lru_vec[j]   = (CW'(j) < used_count) &&
                     ({1'b0, recency_rank[j]} == used_count - 1'b1);
    end
    for (int j = ENTRIES-1; j >= 0; j--) begin
      if (match_vec[j]) match_idx = IW'(j);
      if (lru_vec[j])   lru_idx   = IW'(j);
    end
    match_any = |match_vec;
  end

  always_comb begin
    sat_len = (req.write_length > LEN_W'(BLOCK_BYTES)) ? LEN_W'(BLOCK_BYTES)
                                                        : req.write_length;
    for (int b = 0; b < DATA_W/8; b++) begin
      masked_data[b*8 +: 8] = (LEN_W'(b) < sat_len) ? req.write_data[b*8 +: 8] : 8'h00;
    end
  end

  assign q_ready   = (state == S_IDLE);
  assign out_valid = (state == S_RESULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            req   <= q_req;
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          found <= match_any;
          if (match_any) begin
            idx      <= match_idx;
            old_rank <= recency_rank[match_idx];
          end else if (used_count != CW'(ENTRIES)) begin
            idx      <= used_count[IW-1:0];
            old_rank <= IW'(ENTRIES-1);
          end else begin
            idx      <= lru_idx;
            old_rank <= recency_rank[lru_idx];
          end
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (req.func == FUNC_GET && !found) begin
            hit         <= 1'b0;
            read_data   <= '0;
            read_length <= '0;
          end else begin
            // age the more recent entries, promote the chosen one
            for (int j = 0; j < ENTRIES; j++) begin
              if ((CW'(j) < used_count) && (recency_rank[j] < old_rank))
                recency_rank[j] <= recency_rank[j] + 1'b1;
            end
            recency_rank[idx] <= '0;
            hit <= found;
            if (req.func == FUNC_PUT) begin
              entry_key[idx]     <= req.key;
              entry_payload[idx] <= masked_data;
              entry_bytes[idx]   <= sat_len;
              read_data          <= masked_data;
              read_length        <= sat_len;
              if (!found && used_count != CW'(ENTRIES))
                used_count <= used_count + 1'b1;
            end else begin
              read_data   <= entry_payload[idx];
              read_length <= entry_bytes[idx];
            end
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/lru_keyed_block_cache.sv]
// Fully associative LRU cache of ENTRIES blocks keyed by a 32-bit id. A get
// (func 0) returns the payload and length of a present key and makes it most
// recent; a miss returns all zeros and changes nothing. A put (func 1) writes
// the key's entry, a free entry, or the least recently used one when full,
// storing only write_length bytes (saturated to BLOCK_BYTES) with zeros above.
// Every transaction returns one result. A two-deep request queue takes
// transactions while the back end works; the back end takes each one through
// queue pop, key compare across all entries, recency update and entry write,
// and result hold, and pops no new transaction until the result is accepted.
// No clearing pass after reset.
module lru_keyed_block_cache import lkbc_pkg::*; #(
  parameter int ENTRIES     = 16,
  parameter int BLOCK_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [KEY_W-1:0]  key,
  input  logic [DATA_W-1:0] write_data,
  input  logic [LEN_W-1:0]  write_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [DATA_W-1:0] read_data,
  output logic [LEN_W-1:0]  read_length
);

  lkbc_req_t in_req;
  lkbc_req_t q_req;
  logic      q_valid;
  logic      q_ready;

  assign in_req = '{func: func, key: key, write_data: write_data,
                    write_length: write_length};

  // Front: hold incoming transactions in a short queue.
  lkbc_front #(.DEPTH(2)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_req,
    .q_valid, .q_ready, .q_req
  );

  // Back: look up, update recency, write entry, present result.
  lkbc_back #(.ENTRIES(ENTRIES), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req,
    .out_valid, .out_ready, .hit, .read_data, .read_length
  );

  // A result never appears with the length above the block size.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> read_length <= LEN_W'(BLOCK_BYTES))
    else $error("read_length exceeds block size");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(hit))
    else $error("stalled result changed");

  // A get miss returns zeros.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit && u_back.req.func == FUNC_GET |-> read_data == '0)
    else $error("get miss returned data");

endmodule
